// ===== src/utf8_byte_decoder_assert.svh =====
// Assertion macros for the checker file (u8dec_checker.sv).
`ifndef UTF8_BYTE_DECODER_ASSERT_SVH
`define UTF8_BYTE_DECODER_ASSERT_SVH

// Clocked property with an active-low reset disable.
`define U8DEC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Implication form: when cond holds, expr must hold in the same cycle.
`define U8DEC_ASSERT_IMPL(lbl, clk, rstn, cond, expr, msg) \
    `U8DEC_ASSERT(lbl, clk, rstn, (cond) |-> (expr), msg)

`endif

// ===== src/u8dec_pkg.sv =====
package u8dec_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEAD = 2'd1;
    localparam logic [1:0] STATUS_TRUNC    = 2'd2;
    localparam logic [1:0] STATUS_UNUSED   = 2'd3;

    localparam int unsigned CP_W = 20;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [CP_W-1:0] partial_code;
        logic [1:0]      bytes_left;
    } dec_state_t;

    // One result transaction
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
        logic            final_result;
    } dec_result_t;

endpackage

// ===== src/utf8_byte_decoder.sv =====
// Channel  Direction  Payload                               Handshake
// s_       in         in_byte[7:0], end_of_text             s_valid / s_ready
// m_       out        code_point[19:0], status[1:0],        m_valid / m_ready
//                     final_result
//
// One byte is accepted per cycle while s_ready is high; its result, if any, is shown
// in the next cycle from the result register. Throughput is one byte per cycle
// when not stalled, set by the single state register loop (partial code and bytes left).
// s_ready drops only while a result is held and m_ready is low.
// aresetn is synchronous, active low, and clears the state and m_valid.
module utf8_byte_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_in_byte,
    input  logic                      s_end_of_text,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [u8dec_pkg::CP_W-1:0] m_code_point,
    output logic [1:0]                m_status,
    output logic                      m_final_result
);
    import u8dec_pkg::*;

    dec_state_t      state_reg;
    dec_state_t      state_next;
    dec_result_t     step_res;
    logic            m_valid_reg;
    logic [CP_W-1:0] code_point_reg;
    logic [1:0]      status_reg;
    logic            final_reg;
    logic            s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    u8dec_step u_step (
        .in_byte     (s_in_byte),
        .end_of_text (s_end_of_text),
        .state       (state_reg),
        .state_next  (state_next),
        .result      (step_res)
    );

    // State and valid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_valid_reg <= step_res.emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on every accepted byte that emits a result
    always_ff @(posedge aclk) begin
        if (s_accept && step_res.emit) begin
            code_point_reg <= step_res.code_point;
            status_reg     <= step_res.status;
            final_reg      <= step_res.final_result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_code_point   = code_point_reg;
    assign m_status       = status_reg;
    assign m_final_result = final_reg;

endmodule

// ===== src/u8dec_step.sv =====
module u8dec_step (
    input  logic [7:0]              in_byte,
    input  logic                    end_of_text,
    input  u8dec_pkg::dec_state_t   state,
    output u8dec_pkg::dec_state_t   state_next,
    output u8dec_pkg::dec_result_t  result
);
    import u8dec_pkg::*;

    logic [CP_W-1:0] shifted;
    logic [1:0]      left_dec;

    assign shifted  = {state.partial_code[CP_W-7:0], in_byte[5:0]};
    assign left_dec = state.bytes_left - 2'd1;

    // Lead / continuation decode for one byte
    always_comb begin
        state_next          = state;
        result.emit         = 1'b0;
        result.code_point   = '0;
        result.status       = STATUS_OK;
        result.final_result = end_of_text;

        case (state.bytes_left)
            2'd0: begin
                if (!in_byte[7]) begin
                    result.emit       = 1'b1;
                    result.code_point = {{(CP_W-8){1'b0}}, in_byte};
                end else if (in_byte[7:5] == 3'b110) begin
                    state_next.partial_code = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                    state_next.bytes_left   = 2'd1;
                end else if (in_byte[7:4] == 4'b1110) begin
                    state_next.partial_code = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                    state_next.bytes_left   = 2'd2;
                end else if (in_byte[7:2] == 6'b111100) begin
                    state_next.partial_code = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                    state_next.bytes_left   = 2'd3;
                end else begin
                    // continuation byte or F4..FF where a lead is expected
                    state_next.partial_code = '0;
                    state_next.bytes_left   = 2'd0;
                    result.emit             = 1'b1;
                    result.status           = STATUS_BAD_LEAD;
                end
            end
            default: begin
                state_next.partial_code = shifted;
                state_next.bytes_left   = left_dec;
                if (left_dec == 2'd0) begin
                    result.emit             = 1'b1;
                    result.code_point       = shifted;
                    state_next.partial_code = '0;
                end
            end
        endcase

        // stream ends inside a sequence
        if (!result.emit && end_of_text) begin
            state_next.partial_code = '0;
            state_next.bytes_left   = 2'd0;
            result.emit             = 1'b1;
            result.code_point       = '0;
            result.status           = STATUS_TRUNC;
            result.final_result     = 1'b1;
        end
    end

endmodule

// ===== src/u8dec_checker.sv =====
`include "utf8_byte_decoder_assert.svh"

module u8dec_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [7:0]                 s_in_byte,
    input logic                       s_end_of_text,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [u8dec_pkg::CP_W-1:0] m_code_point,
    input logic [1:0]                 m_status,
    input logic                       m_final_result
);
    import u8dec_pkg::*;

    // result held until taken
    `U8DEC_ASSERT(a_m_valid_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "m_valid dropped")
    // only defined status codes appear
    `U8DEC_ASSERT_IMPL(a_status_code, aclk, aresetn, m_valid, m_status != STATUS_UNUSED, "bad status")
    // error results carry a zero code point
    `U8DEC_ASSERT_IMPL(a_err_zero_cp, aclk, aresetn, m_valid && m_status != STATUS_OK, m_code_point == '0, "err cp nonzero")
    // truncation is only reported at the end of a stream
    `U8DEC_ASSERT_IMPL(a_trunc_final, aclk, aresetn, m_valid && m_status == STATUS_TRUNC, m_final_result, "trunc not final")

endmodule

bind utf8_byte_decoder u8dec_checker u_u8dec_checker (.*);
